[sv/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/pic_pkg.sv]
package pic_pkg;
  localparam int NumSources   = 63;
  localparam int PrioBits     = 3;
  localparam int IdBits       = 6;
  localparam int WordShift    = 5;
  localparam int NumWords     = (NumSources >> WordShift) + 1;
  localparam logic [21:0] PendingBase   = 22'h001000;
  localparam logic [21:0] EnableBase    = 22'h002000;
  localparam logic [21:0] ThresholdAddr = 22'h200000;
  localparam logic [21:0] ClaimAddr     = 22'h200004;
  localparam logic [1:0] ModeRaise = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;
  // per-source entry: priority, enable, pending, claimed
  localparam int EntryBits = PrioBits + 3;
  typedef struct packed {
    logic [PrioBits-1:0] prio;
    logic                en;
    logic                pend;
    logic                clm;
  } entry_t;
endpackage

[sv/pic_if.sv]
interface pic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [21:0] address;
  logic [31:0] write_data;
  logic [5:0]  source_id;
  modport source (output valid, mode, address, write_data, source_id, input ready);
  modport sink (input valid, mode, address, write_data, source_id, output ready);
endinterface

interface pic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        external_irq;
  logic        bad_address;
  modport source (output valid, read_data, external_irq, bad_address, input ready);
  modport sink (input valid, read_data, external_irq, bad_address, output ready);
endinterface

[sv/pic_ram.sv]
module pic_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/platform_interrupt_controller.sv]
// Single-target platform interrupt controller. Per-source state (priority, enable,
// pending, claimed) lives in one 64-entry RAM. After reset a clearing pass writes every
// entry to zero before the first item is taken. Every item then runs a scan of all 64
// entries through the RAM read port (one entry a cycle) to work out the winning source,
// then applies the access (a read step, then a write step), then rescans for
// external_irq before the result is offered. An enable word write sweeps 32 entries,
// with a read step and a write step for each. The scans run one after another because
// the RAM has a single read port. Word reads of pending or enable bits gather their 32
// bits during the scan.
`include "assert_macros.svh"
module platform_interrupt_controller import pic_pkg::*; (
  input logic clk,
  input logic rst_n,
  pic_in_if.sink    in_ch,
  pic_out_if.source out_ch
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_APPLY, S_RESCAN, S_DONE} state_t;
  state_t state_r;

  logic [IdBits:0]   cnt_r;       // scan counter, reaches 64
  logic              rvalid_r;    // RAM data for entry cnt_r-1 arrives this cycle
  logic [IdBits-1:0] ridx_r;
  logic [1:0]        mode_r;
  logic [21:0]       addr_r;
  logic [31:0]       wdata_r;
  logic [IdBits-1:0] src_r;
  logic [PrioBits-1:0] thr_r;
  logic [IdBits-1:0] best_r;
  logic [PrioBits-1:0] bprio_r;
  logic [31:0]       pword_r, eword_r;
  logic [PrioBits-1:0] pr_r;      // priority of addressed source
  logic              sub_r;       // apply sub-step: 0 issue read, 1 write
  logic              irq_r;
  logic [31:0]       rd_r;
  logic              bad_r;
  logic              ovalid_r;

  logic              we;
  logic [IdBits-1:0] waddr, raddr;
  entry_t            wd, rd;

  pic_ram #(.Width(EntryBits), .Depth(1 << IdBits)) u_ram (
    .clk, .we, .waddr, .wdata(wd), .raddr, .rdata(rd)
  );

  // decode
  logic mis, in_prio, in_pend, in_en, is_thr, is_clm, bad_d;
  logic [IdBits-1:0] prio_id;
  logic [21:0] poff, eoff;
  always_comb begin
    poff    = addr_r - PendingBase;
    eoff    = addr_r - EnableBase;
    mis     = addr_r[1:0] != 2'd0;
    in_prio = addr_r < PendingBase;
    prio_id = addr_r[IdBits+1:2];
    in_pend = addr_r >= PendingBase && addr_r < PendingBase + 22'(4 * NumWords);
    in_en   = addr_r >= EnableBase && addr_r < EnableBase + 22'(4 * NumWords);
    is_thr  = addr_r == ThresholdAddr;
    is_clm  = addr_r == ClaimAddr;
    bad_d   = mis || (in_prio && addr_r[11:2] > 10'(NumSources))
              || !(in_prio || in_pend || in_en || is_thr || is_clm);
  end
  logic acc;
  assign acc = mode_r == ModeWrite || mode_r == ModeRead;
  logic word_sel;
  assign word_sel = in_pend ? poff[2] : eoff[2];
  logic cpl_hit;
  assign cpl_hit = wdata_r >= 32'd1 && wdata_r <= 32'(NumSources);

  // entry under scan
  logic hit;
  assign hit = rvalid_r && ridx_r != '0 && rd.pend && rd.en && rd.prio > bprio_r;

  // apply target
  logic [IdBits-1:0] tgt;
  always_comb begin
    tgt = '0;
    if (mode_r == ModeRaise) tgt = src_r;
    else if (is_clm && mode_r == ModeRead) tgt = best_r;
    else if (is_clm) tgt = wdata_r[IdBits-1:0];
    else if (in_prio) tgt = prio_id;
    else tgt = {word_sel, 5'd0} + cnt_r[IdBits-1:0];
  end

  always_comb begin
    we = 1'b0; waddr = tgt; wd = rd; raddr = cnt_r[IdBits-1:0];
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt_r[IdBits-1:0]; wd = '0;
      end
      S_APPLY: begin
        raddr = tgt;
        // a raise ignores the address field
        if (sub_r && !(acc && bad_d)) begin
          if (mode_r == ModeRaise) begin
            we = src_r != '0 && !rd.clm; wd.pend = 1'b1;
          end else if (mode_r == ModeWrite && in_prio) begin
            we = prio_id != '0; wd.prio = wdata_r[PrioBits-1:0];
          end else if (mode_r == ModeWrite && in_en) begin
            // enable words sweep entries one by one via cnt_r, each with a read and a write step
            we = tgt != '0; wd.en = wdata_r[cnt_r[4:0]];
          end else if (mode_r == ModeWrite && is_clm) begin
            we = cpl_hit && rd.clm && rd.en; wd.clm = 1'b0;
          end else if (mode_r == ModeRead && is_clm) begin
            we = best_r != '0; wd.pend = 1'b0; wd.clm = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = state_r == S_IDLE && !ovalid_r;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.read_data    = rd_r;
  assign out_ch.external_irq = irq_r;
  assign out_ch.bad_address  = bad_r;

  logic en_sweep;
  assign en_sweep = mode_r == ModeWrite && in_en && !bad_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
      thr_r    <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      rvalid_r <= (state_r == S_SCAN || state_r == S_RESCAN) && cnt_r < 7'(1 << IdBits);
      ridx_r   <= cnt_r[IdBits-1:0];
      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r == 7'(1 << IdBits) - 7'd1) begin
            state_r <= S_IDLE; cnt_r <= '0;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          mode_r <= in_ch.mode; addr_r <= in_ch.address;
          wdata_r <= in_ch.write_data; src_r <= in_ch.source_id;
          cnt_r <= '0; best_r <= '0; bprio_r <= thr_r;
          pword_r <= '0; eword_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN, S_RESCAN: begin
          if (cnt_r < 7'(1 << IdBits)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (hit) begin
            best_r <= ridx_r; bprio_r <= rd.prio;
          end
          if (rvalid_r && ridx_r != '0) begin
            if (ridx_r[5] == word_sel) begin
              pword_r[ridx_r[4:0]] <= rd.pend;
              eword_r[ridx_r[4:0]] <= rd.en;
            end
            if (ridx_r == prio_id) pr_r <= rd.prio;
          end
          if (!rvalid_r && cnt_r == 7'(1 << IdBits)) begin
            cnt_r <= '0; sub_r <= 1'b0;
            if (state_r == S_SCAN) state_r <= S_APPLY;
            else begin
              irq_r <= best_r != '0 || hit; state_r <= S_DONE;
            end
          end
        end
        S_APPLY: begin
          sub_r <= ~sub_r;
          if (sub_r) begin
            if (en_sweep && cnt_r != 7'd31) cnt_r <= cnt_r + 1'b1;
            else begin
              cnt_r <= '0; state_r <= S_RESCAN;
              best_r <= '0;
              if (mode_r == ModeWrite && is_thr) begin
                thr_r   <= wdata_r[PrioBits-1:0];
                bprio_r <= wdata_r[PrioBits-1:0];
              end else bprio_r <= thr_r;
              bad_r <= acc && bad_d;
              if (mode_r == ModeRead && !bad_d) begin
                priority case (1'b1)
                  in_prio: rd_r <= 32'(pr_r) & {32{prio_id != '0}};
                  in_pend: rd_r <= pword_r;
                  in_en:   rd_r <= eword_r;
                  is_thr:  rd_r <= 32'(thr_r);
                  default: rd_r <= 32'(best_r);
                endcase
              end else rd_r <= '0;
            end
          end
        end
        S_DONE: begin
          ovalid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, in_ch.ready, state_r == S_IDLE)
  `ASSERT_IMPL(a_no_we_idle, state_r == S_IDLE, !we)
  `ASSERT_NEXT(a_done_valid, state_r == S_DONE, out_ch.valid)
endmodule

[tb/pic_tb_if.sv]
`timescale 1ns / 100ps
// The block's channel interfaces (pic_in_if, pic_out_if) come with the RTL.
// This file only holds a shared record of the expected result.
package pic_tb_pkg;
  typedef struct packed {
    logic [31:0] read_data;
    logic        external_irq;
    logic        bad_address;
  } pic_result_t;
endpackage

[tb/pic_checker.sv]
`timescale 1ns / 100ps
module pic_checker import pic_pkg::*; import pic_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pic_in_if.sink   in_mon,
  pic_out_if.sink  out_mon,
  output int       n_fail,
  output int       n_waiting
);
  logic [PrioBits-1:0] prio_q [NumSources+1];
  logic [NumSources:0] en_q, pend_q, clm_q;
  logic [PrioBits-1:0] thresh_q;
  pic_result_t         result_q [$];

  // winning source: highest priority above threshold, ties to lowest id
  function automatic int winner();
    int best;
    logic [PrioBits-1:0] best_prio;
    best = 0;
    best_prio = thresh_q;
    for (int id = 1; id <= NumSources; id++)
      if (pend_q[id] && en_q[id] && prio_q[id] > best_prio) begin
        best = id;
        best_prio = prio_q[id];
      end
    return best;
  endfunction

  function automatic logic [31:0] word_of(logic [NumSources:0] bits, int w);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 32; b++)
      if (32*w + b >= 1 && 32*w + b <= NumSources && bits[32*w + b]) v[b] = 1'b1;
    return v;
  endfunction

  task automatic apply_item(logic [1:0] mode, logic [21:0] addr, logic [31:0] data,
                            logic [5:0] src);
    pic_result_t r;
    logic wr;
    int id, w;
    r = '0;
    wr = (mode == ModeWrite);
    if (mode == ModeRaise) begin
      if (src >= 1 && src <= NumSources && !clm_q[src]) pend_q[src] = 1'b1;
    end else if (mode == ModeWrite || mode == ModeRead) begin
      if (addr[1:0] != 2'b00) r.bad_address = 1'b1;
      else if (addr < PendingBase) begin
        id = addr >> 2;
        if (id > NumSources) r.bad_address = 1'b1;
        else if (wr) begin
          if (id != 0) prio_q[id] = data[PrioBits-1:0];
        end else r.read_data = prio_q[id];
      end else if (addr < PendingBase + 4*NumWords) begin
        if (!wr) r.read_data = word_of(pend_q, (addr - PendingBase) >> 2);
      end else if (addr >= EnableBase && addr < EnableBase + 4*NumWords) begin
        w = (addr - EnableBase) >> 2;
        if (wr) begin
          for (int b = 0; b < 32; b++)
            if (32*w + b >= 1 && 32*w + b <= NumSources) en_q[32*w + b] = data[b];
        end else r.read_data = word_of(en_q, w);
      end else if (addr == ThresholdAddr) begin
        if (wr) thresh_q = data[PrioBits-1:0];
        else r.read_data = thresh_q;
      end else if (addr == ClaimAddr) begin
        if (wr) begin
          if (data >= 1 && data <= NumSources && clm_q[data] && en_q[data])
            clm_q[data] = 1'b0;
        end else begin
          id = winner();
          if (id != 0) begin
            pend_q[id] = 1'b0;
            clm_q[id] = 1'b1;
          end
          r.read_data = id;
        end
      end else r.bad_address = 1'b1;
    end
    r.external_irq = (winner() != 0);
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    pic_result_t e;
    if (!rst_n) begin
      for (int i = 0; i <= NumSources; i++) prio_q[i] = '0;
      en_q = '0;
      pend_q = '0;
      clm_q = '0;
      thresh_q = '0;
      result_q.delete();
      n_fail = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        apply_item(in_mon.mode, in_mon.address, in_mon.write_data, in_mon.source_id);
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected");
          n_fail++;
        end else begin
          e = result_q.pop_front();
          if (out_mon.read_data !== e.read_data) begin
            $error("read_data: expected %h, got %h", e.read_data, out_mon.read_data);
            n_fail++;
          end
          if (out_mon.external_irq !== e.external_irq) begin
            $error("external_irq: expected %b, got %b", e.external_irq,
                   out_mon.external_irq);
            n_fail++;
          end
          if (out_mon.bad_address !== e.bad_address) begin
            $error("bad_address: expected %b, got %b", e.bad_address,
                   out_mon.bad_address);
            n_fail++;
          end
        end
      end
    end
    n_waiting = result_q.size();
  end
endmodule

[tb/platform_interrupt_controller_tb.sv]
`timescale 1ns / 100ps
module platform_interrupt_controller_tb import pic_pkg::*; import pic_tb_pkg::*;;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_fail, n_waiting;
  int   cycle_cnt = 0;
  bit   long_hold = 1'b0;
  localparam int CycleLimit = 1500000;

  pic_in_if  in_ch ();
  pic_out_if out_ch ();

  platform_interrupt_controller i_dut (.clk, .rst_n, .in_ch(in_ch.sink),
                                       .out_ch(out_ch.source));
  pic_checker i_checker (.clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                         .n_fail, .n_waiting);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || long_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (400) @(posedge clk);
    long_hold = 1'b1;
    repeat (2000) @(posedge clk);
    long_hold = 1'b0;
  end

  int gap_left = 0, burst_left = 0;

  // valid stays high between items of a burst; it drops only for a gap
  task automatic send(logic [1:0] mode, logic [21:0] addr, logic [31:0] data,
                      logic [5:0] src);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
    end
    if (gap_left > 0) in_ch.valid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.address <= addr;
    in_ch.write_data <= data;
    in_ch.source_id <= src;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [21:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1: return 22'($urandom_range(0, NumSources) << 2);
      2: return PendingBase + 22'($urandom_range(0, NumWords - 1) << 2);
      3: return EnableBase + 22'($urandom_range(0, NumWords - 1) << 2);
      4: return ThresholdAddr;
      5, 6: return ClaimAddr;
      7: return 22'($urandom_range(0, 22'h3fffff));
      8: return 22'($urandom_range(0, 255));
      default: return ClaimAddr + 22'($urandom_range(1, 7));
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] m;
    logic [31:0] d;
    in_ch.valid = 1'b0;
    in_ch.mode = ModeRaise;
    in_ch.address = '0;
    in_ch.write_data = '0;
    in_ch.source_id = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed part
    send(ModeWrite, EnableBase, 32'hffff_ffff, '0);
    send(ModeWrite, EnableBase + 4, 32'hffff_ffff, '0);
    send(ModeWrite, 22'd4 * 5, 32'hffff_fffd, '0);   // wide data trimmed
    send(ModeWrite, 22'd4 * 63, 32'd5, '0);
    send(ModeWrite, 22'd0, 32'd7, '0);               // source zero write dropped
    send(ModeRead, 22'd0, '0, '0);
    send(ModeRaise, '0, '0, 6'd0);
    send(ModeRaise, '0, '0, 6'd5);
    send(ModeRaise, '0, '0, 6'd63);
    send(ModeWrite, PendingBase, 32'hffff_ffff, '0);  // pending is read only
    send(ModeRead, PendingBase, '0, '0);
    send(ModeRead, PendingBase + 4, '0, '0);
    send(ModeRead, EnableBase + 4, '0, '0);
    send(ModeRead, ClaimAddr, '0, '0);
    send(ModeRaise, '0, '0, 6'd5);                    // claimed: ignored
    send(ModeWrite, ThresholdAddr, 32'hffff_fffc, '0);
    send(ModeRead, ThresholdAddr, '0, '0);
    send(ModeRead, ClaimAddr, '0, '0);
    send(ModeWrite, ThresholdAddr, 32'd0, '0);
    send(ModeWrite, ClaimAddr, 32'd5, '0);
    send(ModeWrite, ClaimAddr, 32'hffff_ffff, '0);
    send(ModeRead, 22'h000102, '0, '0);              // misaligned
    send(ModeRead, 22'h000100, '0, '0);              // beyond last source
    send(ModeWrite, 22'h3ffffc, 32'd1, '0);
    send(ModeNop, 22'h3fffff, 32'hffff_ffff, 6'h3f);
    drain();
    // random part
    for (int i = 0; i < 1500; i++) begin
      if (i == 700) drain();
      m = 2'($urandom_range(0, 9) < 4 ? ModeRaise : $urandom_range(1, 3));
      d = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($urandom_range(0, 70));
      send(m, (m == ModeRaise) ? 22'($urandom()) : pick_addr(), d, 6'($urandom()));
    end
    drain();
    repeat (300) @(posedge clk);
    if (n_fail == 0 && n_waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/pic_pkg.sv
sv/pic_if.sv
sv/pic_ram.sv
sv/platform_interrupt_controller.sv
tb/pic_tb_if.sv
tb/pic_checker.sv
tb/platform_interrupt_controller_tb.sv
